FILE: src/sfd_pkg.sv
// Shared types and constants for the sensor frame deframer.
// Used by the front parser, the operation queue, the back end and the top level.
`default_nettype none

package sfd_pkg;

	localparam logic [7:0] SYNC_RESET = 8'hAA;
	localparam logic [7:0] CMD_RESET  = 8'h81;

	// Body length counts the command byte, so a 34-byte length field means 35 body bytes.
	localparam logic [16:0] GOOD_BODY_LEN = 17'd35;
	localparam logic [16:0] MIN_RECORD_LEN = 17'd2;
	localparam logic [16:0] CAPTURE_BYTES = 17'd31;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic REG_SYNC = 1'b0;
	localparam logic REG_CMD  = 1'b1;

	// Payload byte positions of the captured fields.
	localparam logic [4:0] IDX_ID      = 5'd0;
	localparam logic [4:0] IDX_HEAD_HI = 5'd6;
	localparam logic [4:0] IDX_HEAD_LO = 5'd7;
	localparam logic [4:0] IDX_X_3     = 5'd18;
	localparam logic [4:0] IDX_X_2     = 5'd19;
	localparam logic [4:0] IDX_X_1     = 5'd20;
	localparam logic [4:0] IDX_X_0     = 5'd21;
	localparam logic [4:0] IDX_Y_3     = 5'd22;
	localparam logic [4:0] IDX_Y_2     = 5'd23;
	localparam logic [4:0] IDX_Y_1     = 5'd24;
	localparam logic [4:0] IDX_Y_0     = 5'd25;
	localparam logic [4:0] IDX_RIGHT_HI = 5'd26;
	localparam logic [4:0] IDX_RIGHT_LO = 5'd27;
	localparam logic [4:0] IDX_LEFT_HI = 5'd28;
	localparam logic [4:0] IDX_LEFT_LO = 5'd29;
	localparam logic [4:0] IDX_MOTION  = 5'd30;

	// One operation handed from the parser to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic       cap;
		logic [4:0] idx;
		logic       emit;
		logic       good;
	} sfd_op_t;

endpackage

`default_nettype wire

FILE: src/sfd_front.sv
// Front parser of the deframer: hunts for sync, reads the length and walks the body.
// Emits capture and record operations as sfd_op_t; depends on sfd_pkg.
`default_nettype none

module sfd_front
	import sfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] sync_byte,
	input  wire logic [7:0] record_command,
	output sfd_op_t         op,
	output logic            op_push
);

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_LEN_HI = 2'd1;
	localparam logic [1:0] PH_LEN_LO = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	logic [1:0]  phase_q;
	logic [7:0]  len_hi_q;
	logic [16:0] body_length_q;
	logic [16:0] body_index_q;
	logic [7:0]  frame_command_q;

	logic [16:0] next_index;
	logic [16:0] pay_index;
	logic        last_byte;
	logic [7:0]  cmd_now;
	logic        in_body;

	assign in_body    = (phase_q == PH_BODY);
	assign next_index = body_index_q + 17'd1;
	assign pay_index  = body_index_q - 17'd1;
	assign last_byte  = in_body && !(next_index < body_length_q);
	assign cmd_now    = (body_index_q == 17'd0) ? rx_byte : frame_command_q;

	always_comb begin
		op.data = rx_byte;
		op.cap  = in_body && (body_index_q != 17'd0) && (pay_index < CAPTURE_BYTES);
		op.idx  = pay_index[4:0];
		op.emit = last_byte && !(body_length_q < MIN_RECORD_LEN) && (cmd_now == record_command);
		op.good = (body_length_q == GOOD_BODY_LEN);
		op_push = take && (op.cap || op.emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			len_hi_q        <= 8'd0;
			body_length_q   <= 17'd0;
			body_index_q    <= 17'd0;
			frame_command_q <= 8'd0;
		end else if (take) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == sync_byte) begin
						phase_q <= PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					len_hi_q <= rx_byte;
					phase_q  <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					body_length_q <= {1'b0, len_hi_q, rx_byte} + 17'd1;
					body_index_q  <= 17'd0;
					phase_q       <= PH_BODY;
				end
				PH_BODY: begin
					if (body_index_q == 17'd0) begin
						frame_command_q <= rx_byte;
					end
					if (last_byte) begin
						body_index_q <= 17'd0;
						phase_q      <= PH_HUNT;
					end else begin
						body_index_q <= next_index;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/sfd_queue.sv
// Short operation queue between the front parser and the back end.
// Holds sfd_op_t entries; depends on sfd_pkg.
`default_nettype none

module sfd_queue
	import sfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  sfd_op_t   push_op,
	input  wire logic pop,
	output sfd_op_t   head_op,
	output logic      not_empty,
	output logic      full
);

	sfd_op_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_op   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/sfd_back.sv
// Back end of the deframer: applies captured payload bytes and builds records.
// Drives the record output register; depends on sfd_pkg.
`default_nettype none

module sfd_back
	import sfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  sfd_op_t     head_op,
	input  wire logic   not_empty,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [7:0]  record_id,
	output logic [15:0] heading,
	output logic [31:0] pos_x_bits,
	output logic [31:0] pos_y_bits,
	output logic [15:0] right_range_mm,
	output logic [15:0] left_range_mm,
	output logic [7:0]  motion_direction,
	output logic        size_ok
);

	logic [7:0]  id_q;
	logic [15:0] head_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [15:0] right_q;
	logic [15:0] left_q;
	logic [7:0]  motion_q;
	logic        out_valid_q;
	logic        load;

	// A record op waits only while a previous record still sits unconsumed.
	assign pop  = not_empty && (!head_op.emit || !out_valid_q || !out_stall);
	assign load = pop && head_op.emit;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (pop && head_op.cap) begin
			case (head_op.idx)
				IDX_ID:       id_q          <= head_op.data;
				IDX_HEAD_HI:  head_q[15:8]  <= head_op.data;
				IDX_HEAD_LO:  head_q[7:0]   <= head_op.data;
				IDX_X_3:      x_q[31:24]    <= head_op.data;
				IDX_X_2:      x_q[23:16]    <= head_op.data;
				IDX_X_1:      x_q[15:8]     <= head_op.data;
				IDX_X_0:      x_q[7:0]      <= head_op.data;
				IDX_Y_3:      y_q[31:24]    <= head_op.data;
				IDX_Y_2:      y_q[23:16]    <= head_op.data;
				IDX_Y_1:      y_q[15:8]     <= head_op.data;
				IDX_Y_0:      y_q[7:0]      <= head_op.data;
				IDX_RIGHT_HI: right_q[15:8] <= head_op.data;
				IDX_RIGHT_LO: right_q[7:0]  <= head_op.data;
				IDX_LEFT_HI:  left_q[15:8]  <= head_op.data;
				IDX_LEFT_LO:  left_q[7:0]   <= head_op.data;
				IDX_MOTION:   motion_q      <= head_op.data;
				default: begin
				end
			endcase
		end
	end

	// A record of the wrong length carries all-zero fields.
	always_ff @(posedge clk) begin
		if (load) begin
			record_id        <= head_op.good ? id_q     : 8'd0;
			heading          <= head_op.good ? head_q   : 16'd0;
			pos_x_bits       <= head_op.good ? x_q      : 32'd0;
			pos_y_bits       <= head_op.good ? y_q      : 32'd0;
			right_range_mm   <= head_op.good ? right_q  : 16'd0;
			left_range_mm    <= head_op.good ? left_q   : 16'd0;
			motion_direction <= head_op.good ? motion_q : 8'd0;
			size_ok          <= head_op.good;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: src/sensor_frame_deframer_core.sv
// Sensor frame deframer top level: parser, operation queue, record back end, APB registers.
// Takes one byte per cycle while the queue is not full; a record frame's last byte is queued,
// then loaded into the output register once it heads the queue and the output is free.
// A stalled output backs up the four-entry queue before the byte input stalls.
// arst_n clears the parser to sync hunting, empties the queue and restores the registers.
`default_nettype none

module sensor_frame_deframer_core
	import sfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       record_id,
	output logic [15:0]      heading,
	output logic [31:0]      pos_x_bits,
	output logic [31:0]      pos_y_bits,
	output logic [15:0]      right_range_mm,
	output logic [15:0]      left_range_mm,
	output logic [7:0]       motion_direction,
	output logic             size_ok
);

	logic [7:0] sync_byte_q;
	logic [7:0] record_command_q;
	logic       cfg_write;
	logic       take;
	logic       q_full;
	logic       q_not_empty;
	logic       op_push;
	logic       op_pop;
	sfd_op_t    front_op;
	sfd_op_t    head_op;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_CMD) ? {24'd0, record_command_q} : {24'd0, sync_byte_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q      <= SYNC_RESET;
			record_command_q <= CMD_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_SYNC) begin
				sync_byte_q <= pwdata[7:0];
			end else begin
				record_command_q <= pwdata[7:0];
			end
		end
	end

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	sfd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.rx_byte        (rx_byte),
		.sync_byte      (sync_byte_q),
		.record_command (record_command_q),
		.op             (front_op),
		.op_push        (op_push)
	);

	sfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_push),
		.push_op   (front_op),
		.pop       (op_pop),
		.head_op   (head_op),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	sfd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_op          (head_op),
		.not_empty        (q_not_empty),
		.pop              (op_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.record_id        (record_id),
		.heading          (heading),
		.pos_x_bits       (pos_x_bits),
		.pos_y_bits       (pos_y_bits),
		.right_range_mm   (right_range_mm),
		.left_range_mm    (left_range_mm),
		.motion_direction (motion_direction),
		.size_ok          (size_ok)
	);

endmodule

`default_nettype wire

FILE: tb/sfd_record_checker.sv
`timescale 1ns / 1ps
// Record checker for sensor_frame_deframer_core: watches the register port and both channels,
// predicts every sensor record from the accepted byte beats and compares it field by field.
// Depends on sfd_pkg for reset values, body lengths and payload byte positions.

module sfd_record_checker
	import sfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  record_id,
	input  wire logic [15:0] heading,
	input  wire logic [31:0] pos_x_bits,
	input  wire logic [31:0] pos_y_bits,
	input  wire logic [15:0] right_range_mm,
	input  wire logic [15:0] left_range_mm,
	input  wire logic [7:0]  motion_direction,
	input  wire logic        size_ok,
	output int unsigned      mismatches,
	output int unsigned      records_predicted,
	output int unsigned      records_pending,
	output logic             parser_hunting
);

	typedef enum logic [1:0] {ST_HUNT, ST_LEN_HI, ST_LEN_LO, ST_BODY} parse_state_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] heading;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] right_mm;
		logic [15:0] left_mm;
		logic [7:0]  motion;
		logic        ok;
	} sensor_record_t;

	logic [7:0]     sync_val;
	logic [7:0]     cmd_val;
	parse_state_t   pstate;
	logic [16:0]    body_len;
	logic [16:0]    body_idx;
	logic [7:0]     frame_cmd;
	sensor_record_t building;
	sensor_record_t records_due[$];

	// Fields keep their last captured bytes across frames, just as the block does.
	function automatic sensor_record_t place_byte(input sensor_record_t r, input logic [16:0] p,
			input logic [7:0] b);
		case (p)
			IDX_ID:       r.id = b;
			IDX_HEAD_HI:  r.heading[15:8] = b;
			IDX_HEAD_LO:  r.heading[7:0] = b;
			IDX_X_3:      r.pos_x[31:24] = b;
			IDX_X_2:      r.pos_x[23:16] = b;
			IDX_X_1:      r.pos_x[15:8] = b;
			IDX_X_0:      r.pos_x[7:0] = b;
			IDX_Y_3:      r.pos_y[31:24] = b;
			IDX_Y_2:      r.pos_y[23:16] = b;
			IDX_Y_1:      r.pos_y[15:8] = b;
			IDX_Y_0:      r.pos_y[7:0] = b;
			IDX_RIGHT_HI: r.right_mm[15:8] = b;
			IDX_RIGHT_LO: r.right_mm[7:0] = b;
			IDX_LEFT_HI:  r.left_mm[15:8] = b;
			IDX_LEFT_LO:  r.left_mm[7:0] = b;
			IDX_MOTION:   r.motion = b;
			default: ;
		endcase
		return r;
	endfunction

	task automatic take_byte(input logic [7:0] b);
		sensor_record_t rec;
		case (pstate)
			ST_HUNT: if (b == sync_val) pstate = ST_LEN_HI;
			ST_LEN_HI: begin
				body_len = {1'b0, b, 8'h00};
				pstate = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				// The stored length also counts the command byte.
				body_len = body_len + b + 17'd1;
				body_idx = '0;
				pstate = ST_BODY;
			end
			default: begin
				if (body_idx == '0) frame_cmd = b;
				else building = place_byte(building, body_idx - 17'd1, b);
				body_idx = body_idx + 17'd1;
				if (body_idx >= body_len) begin
					pstate = ST_HUNT;
					body_idx = '0;
					if (body_len >= MIN_RECORD_LEN && frame_cmd == cmd_val) begin
						rec = '0;
						if (body_len == GOOD_BODY_LEN) begin
							rec = building;
							rec.ok = 1'b1;
						end
						records_due.push_back(rec);
						records_predicted <= records_predicted + 1;
					end
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches = mismatches + 1;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_record();
		sensor_record_t want;
		if (records_due.size() == 0) begin
			mismatches = mismatches + 1;
			$display("%0t ns: record with id %0h arrived while none was expected",
				$time, record_id);
		end else begin
			want = records_due.pop_front();
			compare_field("record_id", 32'(want.id), 32'(record_id));
			compare_field("heading", 32'(want.heading), 32'(heading));
			compare_field("pos_x_bits", want.pos_x, pos_x_bits);
			compare_field("pos_y_bits", want.pos_y, pos_y_bits);
			compare_field("right_range_mm", 32'(want.right_mm), 32'(right_range_mm));
			compare_field("left_range_mm", 32'(want.left_mm), 32'(left_range_mm));
			compare_field("motion_direction", 32'(want.motion), 32'(motion_direction));
			compare_field("size_ok", 32'(want.ok), 32'(size_ok));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_val = SYNC_RESET;
			cmd_val = CMD_RESET;
			pstate = ST_HUNT;
			body_len = '0;
			body_idx = '0;
			frame_cmd = '0;
			building = '0;
			records_due.delete();
			mismatches = 0;
			records_predicted <= 0;
			records_pending <= 0;
			parser_hunting <= 1'b1;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SYNC) sync_val = pwdata[7:0];
				else cmd_val = pwdata[7:0];
			end
			// The record beat is checked first, so a beat with an empty queue is caught.
			if (out_valid && !out_stall) check_record();
			if (in_valid && !in_stall) take_byte(rx_byte);
			parser_hunting <= (pstate == ST_HUNT);
			records_pending <= records_due.size();
		end
	end

endmodule

FILE: tb/tb_sensor_frame_deframer_core.sv
`timescale 1ns / 1ps
// Top of the sensor_frame_deframer_core testbench: clock, reset, byte, register and stall stimulus.
// Depends on sfd_pkg, the core RTL, and sfd_record_checker, which predicts and compares records.

module tb_sensor_frame_deframer_core;
	import sfd_pkg::*;

	localparam int FILL_RANDOM = -1;
	localparam int FILL_INDEX = -2;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BYTES = 200;
	localparam int PHASE_RECORDS = 4;
	localparam logic [2:0] ADDR_SYNC = {REG_SYNC, 2'b00};
	localparam logic [2:0] ADDR_CMD = {REG_CMD, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  record_id;
	logic [15:0] heading;
	logic [31:0] pos_x_bits;
	logic [31:0] pos_y_bits;
	logic [15:0] right_range_mm;
	logic [15:0] left_range_mm;
	logic [7:0]  motion_direction;
	logic        size_ok;

	int unsigned mismatches;
	int unsigned records_predicted;
	int unsigned records_pending;
	logic        parser_hunting;

	logic [7:0]  sync_now = SYNC_RESET;
	logic [7:0]  cmd_now = CMD_RESET;
	bit          calm = 1'b0;
	int unsigned frames_sent = 0;
	int unsigned framed_bytes = 0;
	int unsigned noise_bytes = 0;
	int unsigned settings_used = 1;
	int unsigned quiet_cycles = 0;

	sensor_frame_deframer_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_id(record_id), .heading(heading), .pos_x_bits(pos_x_bits),
		.pos_y_bits(pos_y_bits), .right_range_mm(right_range_mm),
		.left_range_mm(left_range_mm), .motion_direction(motion_direction), .size_ok(size_ok)
	);

	sfd_record_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_id(record_id), .heading(heading), .pos_x_bits(pos_x_bits),
		.pos_y_bits(pos_y_bits), .right_range_mm(right_range_mm),
		.left_range_mm(left_range_mm), .motion_direction(motion_direction), .size_ok(size_ok),
		.mismatches(mismatches), .records_predicted(records_predicted),
		.records_pending(records_pending), .parser_hunting(parser_hunting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		gap = calm ? 0 : idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic push_noise(input int unsigned count);
		logic [7:0] b;
		repeat (count) begin
			do b = 8'($urandom); while (b == sync_now);
			push_byte(b);
			noise_bytes++;
		end
	endtask

	// Sends sync, length and the first body_sent body bytes; fewer than len+1 cuts the frame.
	task automatic send_frame(input logic [7:0] cmd, input int unsigned len, input int fill,
			input int unsigned body_sent);
		logic [15:0] len_field;
		logic [7:0] b;
		int unsigned i;
		len_field = len[15:0];
		push_byte(sync_now);
		push_byte(len_field[15:8]);
		push_byte(len_field[7:0]);
		for (i = 0; i < body_sent; i++) begin
			if (i == 0) b = cmd;
			else if (fill == FILL_RANDOM) b = 8'($urandom);
			else if (fill == FILL_INDEX) b = i[7:0] + 8'h40;
			else b = fill[7:0];
			push_byte(b);
		end
		frames_sent++;
		framed_bytes += 3 + body_sent;
	endtask

	task automatic send_whole(input logic [7:0] cmd, input int unsigned len, input int fill);
		send_frame(cmd, len, fill, len + 1);
	endtask

	task automatic random_frame();
		int unsigned pick;
		int unsigned len;
		int unsigned sent;
		logic [7:0] cmd;
		calm = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 4));
		pick = $urandom_range(0, 99);
		cmd = cmd_now;
		if (pick < 60) len = 34;
		else if (pick < 72) len = $urandom_range(1, 40);
		else if (pick < 76) len = 0;
		else if (pick < 80) len = $urandom_range(41, 300);
		else if (pick < 92) begin
			do cmd = 8'($urandom); while (cmd == cmd_now);
			len = $urandom_range(0, 40);
		end else len = $urandom_range(5, 40);
		// A cut frame swallows whatever follows it as body bytes.
		sent = (pick >= 92) ? $urandom_range(0, len) : len + 1;
		send_frame(cmd, len, FILL_RANDOM, sent);
	endtask

	// Brings the parser back to sync hunting, then waits for every expected record.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (!parser_hunting) begin
			push_byte(8'h00);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (records_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
		logic [31:0] word;
		word = $urandom;
		word[7:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] s, input logic [7:0] c);
		reg_write(ADDR_SYNC, s);
		reg_write(ADDR_CMD, c);
		sync_now = s;
		cmd_now = c;
		settings_used++;
	endtask

	task automatic random_phase();
		int unsigned byte_goal;
		int unsigned rec_goal;
		byte_goal = framed_bytes + PHASE_BYTES;
		rec_goal = records_predicted + PHASE_RECORDS;
		while (framed_bytes < byte_goal || records_predicted < rec_goal) random_frame();
		settle();
	endtask

	initial begin
		logic [7:0] s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset register values.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h55);
		noise_bytes += 3;
		send_whole(CMD_RESET, 34, 8'h00);
		send_whole(CMD_RESET, 34, 8'hFF);
		send_whole(CMD_RESET, 34, FILL_INDEX);
		send_whole(CMD_RESET, 34, SYNC_RESET);
		send_whole(CMD_RESET, 0, FILL_RANDOM);
		send_whole(CMD_RESET, 1, FILL_RANDOM);
		send_whole(CMD_RESET, 33, FILL_RANDOM);
		send_whole(CMD_RESET, 35, FILL_RANDOM);
		send_whole(8'h01, 34, FILL_RANDOM);
		send_whole(8'h01, 0, FILL_RANDOM);
		send_whole(SYNC_RESET, 34, FILL_RANDOM);
		send_whole(CMD_RESET, 16'h0122, FILL_RANDOM);
		calm = 1'b1;
		repeat (3) send_whole(CMD_RESET, 34, FILL_RANDOM);
		calm = 1'b0;
		settle();

		configure(8'h00, 8'hFF);
		random_phase();
		configure(8'hFF, 8'h00);
		random_phase();
		s = 8'($urandom);
		configure(s, s);
		random_phase();
		configure(8'($urandom), 8'($urandom));
		random_phase();

		$display("Sent %0d frames (%0d framed bytes) and %0d noise bytes;",
			frames_sent, framed_bytes, noise_bytes);
		$display("%0d records were expected under %0d register settings.",
			records_predicted, settings_used);
		if (mismatches == 0 && records_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Record-side backpressure: quiet stretches, short stalls and a few long ones.
	initial begin
		int unsigned r;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				out_stall <= 1'b1;
				repeat (r < 3 ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (r > 90 ? $urandom_range(30, 120) : $urandom_range(1, 4)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no beat for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
